// File: rtl/mig_pkg.sv
// Shared types, constants and helpers of the Gauss-Jordan matrix inverter.
package mig_pkg;

    localparam int DATA_W        = 32;
    localparam int CFG_W         = 4;
    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIM_RESET     = 8;
    localparam int FIFO_DEPTH    = 4;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_PIV_RD,
        ST_PIV_CHK,
        ST_SW_RD,
        ST_SW_WR1,
        ST_SW_WR2,
        ST_RCP_RD,
        ST_RCP_START,
        ST_RCP_WAIT,
        ST_SC_RD,
        ST_SC_MUL,
        ST_SC_WR,
        ST_EL_ERD,
        ST_EL_ECHK,
        ST_EL_RD,
        ST_EL_MUL,
        ST_EL_WR,
        ST_EL_NEXT,
        ST_OUT_RD,
        ST_OUT_HOLD
    } back_state_t;

    typedef struct packed {
        logic              ovf;
        logic [DATA_W-1:0] val;
    } sat_t;

    // clamp to the signed 32-bit range
    function automatic sat_t sat32(input logic signed [64:0] v);
        sat_t              s;
        logic signed [64:0] hi;
        logic signed [64:0] lo;
        hi = 65'sd2147483647;
        lo = -65'sd2147483648;
        if (v > hi) begin
            s.ovf = 1'b1;
            s.val = 32'h7FFF_FFFF;
        end else if (v < lo) begin
            s.ovf = 1'b1;
            s.val = 32'h8000_0000;
        end else begin
            s.ovf = 1'b0;
            s.val = v[DATA_W-1:0];
        end
        return s;
    endfunction

endpackage

// File: rtl/mig_front.sv
// Load front end: size register, element position counters, entry packing.
module mig_front import mig_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic [DATA_W-1:0]    in_data,
    output logic                 in_ready,
    input  logic                 fifo_full,
    output logic                 push,
    output logic [$clog2(MAX_DIM+1)+1+2*$clog2(MAX_DIM)+DATA_W-1:0] push_data
);
    localparam int DIM_W = $clog2(MAX_DIM+1);
    localparam int IDX_W = $clog2(MAX_DIM);

    logic [CFG_W-1:0] dim_reg;
    logic [IDX_W-1:0] row_reg, col_reg;
    logic [DIM_W-1:0] n;
    logic [IDX_W-1:0] nm1;
    logic             last_col, last_row;

    always_comb begin
        if (dim_reg == '0) begin
            n = DIM_W'(1);
        end else if (int'(dim_reg) > MAX_DIM) begin
            n = DIM_W'(MAX_DIM);
        end else begin
            n = DIM_W'(dim_reg);
        end
    end

    assign nm1      = IDX_W'(n - 1'b1);
    assign last_col = (col_reg == nm1);
    assign last_row = (row_reg == nm1);
    assign in_ready = !fifo_full;
    assign push     = in_valid && !fifo_full;
    assign push_data = {n, last_col && last_row, row_reg, col_reg, in_data};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg <= CFG_W'(DIM_RESET);
            row_reg <= '0;
            col_reg <= '0;
        end else if (cfg_valid) begin
            // new size drops any partial load
            dim_reg <= cfg_data;
            row_reg <= '0;
            col_reg <= '0;
        end else if (push) begin
            if (last_col) begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

endmodule

// File: rtl/mig_fifo.sv
// Small register FIFO between load front end and elimination back end.
module mig_fifo import mig_pkg::*; #(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             not_empty
);
    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [PTR_W:0]   cnt_reg;

    assign full      = (cnt_reg == (PTR_W+1)'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == PTR_W'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
    end

endmodule

// File: rtl/mig_recip.sv
// Bit-serial restoring divider for the pivot reciprocal, rounded and clamped.
module mig_recip import mig_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DATA_W-1:0] pivot,
    output logic              done,
    output logic [DATA_W-1:0] result,
    output logic              ovf
);
    localparam int NUM_W = ((2*FRAC_BITS > 30) ? 2*FRAC_BITS : 30) + 1;
    localparam int CNT_W = $clog2(NUM_W+1);

    logic [NUM_W-1:0]  num_reg, quo_reg;
    logic [DATA_W-1:0] rem_reg, den_reg;
    logic              neg_reg, run_reg, done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] den_abs;
    logic [DATA_W:0]   trial;
    logic              take;
    logic [NUM_W:0]    qx;

    assign den_abs = pivot[DATA_W-1] ? DATA_W'(~pivot + 1'b1) : pivot;
    assign trial   = {rem_reg, num_reg[NUM_W-1]};
    assign take    = (trial >= {1'b0, den_reg});
    assign qx      = {1'b0, quo_reg};
    assign done    = done_reg;

    always_comb begin
        ovf    = 1'b0;
        result = DATA_W'(quo_reg);
        if (!neg_reg) begin
            if (qx > (NUM_W+1)'(32'h7FFF_FFFF)) begin
                ovf    = 1'b1;
                result = 32'h7FFF_FFFF;
            end
        end else begin
            if (qx > (NUM_W+1)'(32'h8000_0000)) begin
                ovf    = 1'b1;
                result = 32'h8000_0000;
            end else begin
                result = DATA_W'(~quo_reg[DATA_W-1:0] + 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            // numerator 2^(2F) + |p|/2 gives round to nearest, ties away
            num_reg <= (NUM_W'(1) << (2*FRAC_BITS)) + NUM_W'(den_abs >> 1);
            den_reg <= den_abs;
            neg_reg <= pivot[DATA_W-1];
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (run_reg) begin
            num_reg <= num_reg << 1;
            quo_reg <= {quo_reg[NUM_W-2:0], take};
            rem_reg <= take ? DATA_W'(trial - {1'b0, den_reg}) : trial[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/mig_back.sv
// Elimination back end: matrix memories, Gauss-Jordan sequencer, result stage.
module mig_back import mig_pkg::*; #(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fifo_valid,
    input  logic [$clog2(MAX_DIM+1)+1+2*$clog2(MAX_DIM)+DATA_W-1:0] fifo_data,
    output logic              fifo_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_value,
    output logic              m_last,
    output logic              m_singular,
    output logic              m_saturated
);
    localparam int DIM_W  = $clog2(MAX_DIM+1);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int CELLS  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [DATA_W-1:0] FX_ONE = DATA_W'(1) << FRAC_BITS;
    localparam logic signed [64:0] HALF  = 65'sd1 <<< (FRAC_BITS-1);

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
        return ADDR_W'(int'(r) * MAX_DIM + int'(c));
    endfunction

    back_state_t state_reg, state_next;
    logic [IDX_W-1:0]  i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [DIM_W-1:0]  n_reg, n_next;
    logic [IDX_W-1:0]  nm1;
    logic              sing_reg, sing_next, ovf_reg, ovf_next;
    logic [DATA_W-1:0] recip_reg, recip_next, e_reg, e_next;

    // entry fields
    logic [DATA_W-1:0] ent_value;
    logic [IDX_W-1:0]  ent_row, ent_col;
    logic              ent_last;
    logic [DIM_W-1:0]  ent_n;

    // memories
    logic [DATA_W-1:0] w_mem [CELLS];
    logic [DATA_W-1:0] a_mem [CELLS];
    logic              w_we, a_we, rd_en;
    logic [ADDR_W-1:0] w_waddr, a_waddr, w_ra0, w_ra1, a_ra0, a_ra1;
    logic [DATA_W-1:0] w_wdata, a_wdata;
    logic [DATA_W-1:0] w_rd0_reg, w_rd1_reg, a_rd0_reg, a_rd1_reg;

    // arithmetic
    logic signed [63:0] prod_w_reg, prod_a_reg;
    logic [DATA_W-1:0]  mul_b;
    logic signed [64:0] rnd_w, rnd_a;
    sat_t               sc_w, sc_a, el_w, el_a;

    // reciprocal unit
    logic              rcp_start, rcp_done, rcp_ovf;
    logic [DATA_W-1:0] rcp_result;

    assign ent_value = fifo_data[DATA_W-1:0];
    assign ent_col   = fifo_data[DATA_W +: IDX_W];
    assign ent_row   = fifo_data[DATA_W+IDX_W +: IDX_W];
    assign ent_last  = fifo_data[DATA_W+2*IDX_W];
    assign ent_n     = fifo_data[DATA_W+2*IDX_W+1 +: DIM_W];

    assign nm1 = IDX_W'(n_reg - 1'b1);

    mig_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rcp_start),
        .pivot   (w_rd0_reg),
        .done    (rcp_done),
        .result  (rcp_result),
        .ovf     (rcp_ovf)
    );

    always_ff @(posedge aclk) begin
        if (w_we) begin
            w_mem[w_waddr] <= w_wdata;
        end
        if (rd_en) begin
            w_rd0_reg <= w_mem[w_ra0];
            w_rd1_reg <= w_mem[w_ra1];
        end
    end

    always_ff @(posedge aclk) begin
        if (a_we) begin
            a_mem[a_waddr] <= a_wdata;
        end
        if (rd_en) begin
            a_rd0_reg <= a_mem[a_ra0];
            a_rd1_reg <= a_mem[a_ra1];
        end
    end

    assign mul_b = (state_reg == ST_SC_MUL) ? recip_reg : e_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SC_MUL || state_reg == ST_EL_MUL) begin
            prod_w_reg <= $signed(w_rd0_reg) * $signed(mul_b);
            prod_a_reg <= $signed(a_rd0_reg) * $signed(mul_b);
        end
    end

    // round half up, then floor shift
    assign rnd_w = ($signed({prod_w_reg[63], prod_w_reg}) + HALF) >>> FRAC_BITS;
    assign rnd_a = ($signed({prod_a_reg[63], prod_a_reg}) + HALF) >>> FRAC_BITS;
    assign sc_w  = sat32(rnd_w);
    assign sc_a  = sat32(rnd_a);
    assign el_w  = sat32($signed({{33{w_rd1_reg[DATA_W-1]}}, w_rd1_reg}) - rnd_w);
    assign el_a  = sat32($signed({{33{a_rd1_reg[DATA_W-1]}}, a_rd1_reg}) - rnd_a);

    // next state
    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        sing_next  = sing_reg;
        ovf_next   = ovf_reg;
        recip_next = recip_reg;
        e_next     = e_reg;
        case (state_reg)
            ST_IDLE: begin
                if (fifo_valid) begin
                    n_next = ent_n;
                    if (ent_last) begin
                        state_next = ST_INIT;
                        i_next     = '0;
                        k_next     = '0;
                        sing_next  = 1'b0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            ST_INIT: begin
                if (k_reg == nm1) begin
                    k_next = '0;
                    if (i_reg == nm1) begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = ST_PIV_RD;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_PIV_RD: state_next = ST_PIV_CHK;
            ST_PIV_CHK: begin
                if (w_rd0_reg != '0) begin
                    k_next     = '0;
                    state_next = (i_reg == j_reg) ? ST_RCP_RD : ST_SW_RD;
                end else if (i_reg == nm1) begin
                    sing_next  = 1'b1;
                    i_next     = '0;
                    k_next     = '0;
                    state_next = ST_OUT_RD;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_PIV_RD;
                end
            end
            ST_SW_RD:  state_next = ST_SW_WR1;
            ST_SW_WR1: state_next = ST_SW_WR2;
            ST_SW_WR2: begin
                if (k_reg == nm1) begin
                    state_next = ST_RCP_RD;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_SW_RD;
                end
            end
            ST_RCP_RD:    state_next = ST_RCP_START;
            ST_RCP_START: state_next = ST_RCP_WAIT;
            ST_RCP_WAIT: begin
                if (rcp_done) begin
                    recip_next = rcp_result;
                    ovf_next   = ovf_reg | rcp_ovf;
                    k_next     = '0;
                    state_next = ST_SC_RD;
                end
            end
            ST_SC_RD:  state_next = ST_SC_MUL;
            ST_SC_MUL: state_next = ST_SC_WR;
            ST_SC_WR: begin
                ovf_next = ovf_reg | sc_w.ovf | sc_a.ovf;
                if (k_reg == nm1) begin
                    i_next     = '0;
                    state_next = ST_EL_ERD;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_SC_RD;
                end
            end
            ST_EL_ERD: state_next = (i_reg == j_reg) ? ST_EL_NEXT : ST_EL_ECHK;
            ST_EL_ECHK: begin
                e_next = w_rd0_reg;
                if (w_rd0_reg == '0) begin
                    state_next = ST_EL_NEXT;
                end else begin
                    k_next     = '0;
                    state_next = ST_EL_RD;
                end
            end
            ST_EL_RD:  state_next = ST_EL_MUL;
            ST_EL_MUL: state_next = ST_EL_WR;
            ST_EL_WR: begin
                ovf_next = ovf_reg | el_w.ovf | el_a.ovf;
                if (k_reg == nm1) begin
                    state_next = ST_EL_NEXT;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_EL_RD;
                end
            end
            ST_EL_NEXT: begin
                if (i_reg == nm1) begin
                    if (j_reg == nm1) begin
                        i_next     = '0;
                        k_next     = '0;
                        state_next = ST_OUT_RD;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        i_next     = j_reg + 1'b1;
                        state_next = ST_PIV_RD;
                    end
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_EL_ERD;
                end
            end
            ST_OUT_RD: state_next = ST_OUT_HOLD;
            ST_OUT_HOLD: begin
                if (m_ready) begin
                    if (k_reg == nm1) begin
                        k_next = '0;
                        if (i_reg == nm1) begin
                            state_next = ST_IDLE;
                        end else begin
                            i_next     = i_reg + 1'b1;
                            state_next = ST_OUT_RD;
                        end
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        fifo_pop  = 1'b0;
        rd_en     = 1'b0;
        rcp_start = 1'b0;
        m_valid   = 1'b0;
        w_we      = 1'b0;
        a_we      = 1'b0;
        w_waddr   = cell_addr(i_reg, k_reg);
        a_waddr   = cell_addr(i_reg, k_reg);
        w_wdata   = '0;
        a_wdata   = '0;
        w_ra0     = cell_addr(j_reg, k_reg);
        w_ra1     = cell_addr(i_reg, k_reg);
        a_ra0     = cell_addr(j_reg, k_reg);
        a_ra1     = cell_addr(i_reg, k_reg);
        case (state_reg)
            ST_IDLE: begin
                fifo_pop = fifo_valid;
                w_we     = fifo_valid;
                w_waddr  = cell_addr(ent_row, ent_col);
                w_wdata  = ent_value;
            end
            ST_INIT: begin
                a_we    = 1'b1;
                a_wdata = (i_reg == k_reg) ? FX_ONE : '0;
            end
            ST_PIV_RD: begin
                rd_en = 1'b1;
                w_ra0 = cell_addr(i_reg, j_reg);
            end
            ST_SW_RD: rd_en = 1'b1;
            ST_SW_WR1: begin
                w_we    = 1'b1;
                a_we    = 1'b1;
                w_waddr = cell_addr(j_reg, k_reg);
                a_waddr = cell_addr(j_reg, k_reg);
                w_wdata = w_rd1_reg;
                a_wdata = a_rd1_reg;
            end
            ST_SW_WR2: begin
                w_we    = 1'b1;
                a_we    = 1'b1;
                w_wdata = w_rd0_reg;
                a_wdata = a_rd0_reg;
            end
            ST_RCP_RD: begin
                rd_en = 1'b1;
                w_ra0 = cell_addr(j_reg, j_reg);
            end
            ST_RCP_START: rcp_start = 1'b1;
            ST_SC_RD: rd_en = 1'b1;
            ST_SC_WR: begin
                w_we    = 1'b1;
                a_we    = 1'b1;
                w_waddr = cell_addr(j_reg, k_reg);
                a_waddr = cell_addr(j_reg, k_reg);
                w_wdata = (k_reg == j_reg) ? FX_ONE : sc_w.val;
                a_wdata = sc_a.val;
            end
            ST_EL_ERD: begin
                rd_en = (i_reg != j_reg);
                w_ra0 = cell_addr(i_reg, j_reg);
            end
            ST_EL_RD: rd_en = 1'b1;
            ST_EL_WR: begin
                w_we    = 1'b1;
                a_we    = 1'b1;
                w_wdata = (k_reg == j_reg) ? '0 : el_w.val;
                a_wdata = el_a.val;
            end
            ST_OUT_RD: begin
                rd_en = 1'b1;
                a_ra0 = cell_addr(i_reg, k_reg);
            end
            ST_OUT_HOLD: m_valid = 1'b1;
            default: ;
        endcase
    end

    assign m_value     = sing_reg ? '0 : a_rd0_reg;
    assign m_last      = (i_reg == nm1) && (k_reg == nm1);
    assign m_singular  = sing_reg;
    assign m_saturated = ovf_reg;

    always_ff @(posedge aclk) begin
        recip_reg <= recip_next;
        e_reg     <= e_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            n_reg     <= DIM_W'(1);
            sing_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            sing_reg  <= sing_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// File: rtl/matrix_inverse_gauss_jordan_unit.sv
// Gauss-Jordan matrix inverter top level: loader, entry queue, elimination engine.
// Loading takes one element per cycle while the four-entry queue is not full; the engine drains it.
// Inversion of n x n is set by the read-multiply-write loop over both memories, by the
// bit-serial reciprocal run once per pivot, and by extra rows searched and row swaps.
// Results go out one at a time, each read from memory and then held until taken.
// Reset (aresetn low, synchronous): size 8, load position 0, engine idle, flags clear.
module matrix_inverse_gauss_jordan_unit import mig_pkg::*; #(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // size register write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data,     // matrix_dim
    // element stream in
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,      // element_value
    // inverse stream out
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,      // inverse_value
    output logic              m_tlast,      // last_element
    output logic [1:0]        m_tuser       // [0] singular, [1] saturated
);
    localparam int ENTRY_W = $clog2(MAX_DIM+1) + 1 + 2*$clog2(MAX_DIM) + DATA_W;

    logic               fifo_push, fifo_pop, fifo_full, fifo_valid;
    logic [ENTRY_W-1:0] push_data, pop_data;

    // register writes are always taken at once
    assign cfg_ready = 1'b1;

    // front end: counts row and column, flags the closing element of a matrix
    mig_front #(.MAX_DIM(MAX_DIM)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .in_ready  (s_tready),
        .fifo_full (fifo_full),
        .push      (fifo_push),
        .push_data (push_data)
    );

    // queue decouples loading from a busy engine
    mig_fifo #(.WIDTH(ENTRY_W), .DEPTH(FIFO_DEPTH)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_data (push_data),
        .pop       (fifo_pop),
        .pop_data  (pop_data),
        .full      (fifo_full),
        .not_empty (fifo_valid)
    );

    // back end: writes elements, inverts on the closing one, streams the inverse
    mig_back #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fifo_valid  (fifo_valid),
        .fifo_data   (pop_data),
        .fifo_pop    (fifo_pop),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_value     (m_tdata),
        .m_last      (m_tlast),
        .m_singular  (m_tuser[0]),
        .m_saturated (m_tuser[1])
    );

    // a singular result carries zero data
    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("singular result with nonzero data");

    // engine must not drain the queue while a result transaction is pending
    a_no_pop_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !fifo_pop)
        else $error("queue popped during result output");

    // no pop from an empty queue
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_pop |-> fifo_valid)
        else $error("pop from empty queue");

endmodule

// File: verif/matrix_inverse_gauss_jordan_unit_tb.sv
// Self-checking testbench for the Gauss-Jordan matrix inverter.
module matrix_inverse_gauss_jordan_unit_tb;
    import mig_pkg::*;

    localparam int MAX_DIM   = MAX_DIM_DEF;
    localparam int FRAC_BITS = FRAC_BITS_DEF;
    localparam int CELLS     = MAX_DIM * MAX_DIM;
    localparam logic [DATA_W-1:0] FX_ONE     = 32'h0001_0000;
    localparam logic [DATA_W-1:0] FX_NEG_ONE = 32'hFFFF_0000;  // -1.0
    localparam int STALL_LIMIT = 50000;  // cycles without any transaction
    localparam int DRAIN_WAIT  = 120;    // entry queue drain / trailing latency

    // one pending stimulus transaction: either a matrix element or a size write
    typedef struct {
        bit                is_size;
        logic [DATA_W-1:0] data;
    } stim_t;

    // one expected inverse element
    typedef struct {
        logic [DATA_W-1:0] inv_val;
        logic              last;
        logic              singular;
        logic              saturated;
    } inv_elem_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;     // [31:0] element_value
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;     // [31:0] inverse_value
    logic              m_tlast;     // last_element
    logic [1:0]        m_tuser;     // [0] singular, [1] saturated

    matrix_inverse_gauss_jordan_unit #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // clock: period 20
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    stim_t     stim_q[$];
    inv_elem_t inverse_q[$];

    int  send_idle_pct = 37;
    int  recv_idle_pct = 83;
    bit  run_started   = 1'b0;
    int  mismatches    = 0;
    int  results_seen  = 0;
    int  matrices_done = 0;
    int  singular_seen_cnt = 0;
    int  saturated_seen_cnt = 0;
    int  elems_sent    = 0;
    int  stall_cycles  = 0;

    // previous-edge handshake outcomes, read by the falling-edge driver
    logic elem_taken_q;
    logic size_taken_q;

    // ------------------------------------------------------------------
    // Predictor state: size register, load position, working copies
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  size_reg;
    int                load_pos;
    logic signed [31:0] lhs_mat[CELLS];
    logic signed [31:0] inv_mat[CELLS];
    bit                clamp_flag;

    function automatic int size_in_use();
        if (size_reg < 1) return 1;
        if (size_reg > MAX_DIM) return MAX_DIM;
        return int'(size_reg);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) begin
            clamp_flag = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            clamp_flag = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // rounded fixed-point product; arithmetic shift gives the floor
    function automatic longint fx_mul(logic signed [31:0] a, logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b) + (64'sd1 <<< (FRAC_BITS - 1));
        return p >>> FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] fx_recip(logic signed [31:0] p);
        longint ap;
        longint q;
        ap = (p < 0) ? -longint'(p) : longint'(p);
        q  = ((64'sd1 <<< (2 * FRAC_BITS)) + ap / 2) / ap;
        return clamp32((p < 0) ? -q : q);
    endfunction

    function automatic void swap_rows(int r1, int r2, int n);
        logic signed [31:0] t;
        for (int k = 0; k < n; k++) begin
            t = lhs_mat[r1*MAX_DIM+k];
            lhs_mat[r1*MAX_DIM+k] = lhs_mat[r2*MAX_DIM+k];
            lhs_mat[r2*MAX_DIM+k] = t;
            t = inv_mat[r1*MAX_DIM+k];
            inv_mat[r1*MAX_DIM+k] = inv_mat[r2*MAX_DIM+k];
            inv_mat[r2*MAX_DIM+k] = t;
        end
    endfunction

    // Gauss-Jordan on the loaded matrix; returns 1 when no pivot was found
    function automatic bit gauss_jordan(int n);
        logic signed [31:0] r;
        logic signed [31:0] e;
        int                 i;
        for (int c = 0; c < CELLS; c++) inv_mat[c] = '0;
        for (int d = 0; d < n; d++) inv_mat[d*MAX_DIM+d] = FX_ONE;
        clamp_flag = 1'b0;
        for (int j = 0; j < n; j++) begin
            if (lhs_mat[j*MAX_DIM+j] == 0) begin
                // zero pivot: take the first later row with a nonzero entry
                for (i = j + 1; i < n; i++)
                    if (lhs_mat[i*MAX_DIM+j] != 0) break;
                if (i >= n) return 1'b1;
                swap_rows(j, i, n);
            end
            r = fx_recip(lhs_mat[j*MAX_DIM+j]);
            for (int k = 0; k < n; k++) begin
                lhs_mat[j*MAX_DIM+k] = clamp32(fx_mul(lhs_mat[j*MAX_DIM+k], r));
                inv_mat[j*MAX_DIM+k] = clamp32(fx_mul(inv_mat[j*MAX_DIM+k], r));
            end
            lhs_mat[j*MAX_DIM+j] = FX_ONE;
            for (int row = 0; row < n; row++) begin
                e = lhs_mat[row*MAX_DIM+j];
                if (row != j && e != 0) begin
                    for (int k = 0; k < n; k++) begin
                        lhs_mat[row*MAX_DIM+k] = clamp32(longint'(lhs_mat[row*MAX_DIM+k])
                            - fx_mul(lhs_mat[j*MAX_DIM+k], e));
                        inv_mat[row*MAX_DIM+k] = clamp32(longint'(inv_mat[row*MAX_DIM+k])
                            - fx_mul(inv_mat[j*MAX_DIM+k], e));
                    end
                    lhs_mat[row*MAX_DIM+j] = '0;
                end
            end
        end
        return 1'b0;
    endfunction

    // store one element; on the last one of a matrix queue the whole inverse
    function automatic void load_element(logic [DATA_W-1:0] v);
        int        n;
        int        total;
        bit        sing;
        inv_elem_t x;
        n     = size_in_use();
        total = n * n;
        if (load_pos >= total) load_pos = 0;
        lhs_mat[((load_pos / n) * MAX_DIM + load_pos % n) % CELLS] = v;
        load_pos++;
        if (load_pos < total) return;
        load_pos = 0;
        sing = gauss_jordan(n);
        for (int k = 0; k < total; k++) begin
            x.inv_val   = sing ? '0 : inv_mat[(k / n) * MAX_DIM + k % n];
            x.last      = (k == total - 1);
            x.singular  = sing;
            x.saturated = clamp_flag;
            inverse_q.push_back(x);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: changes inputs on the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        logic  nxt_s_valid;
        logic  nxt_c_valid;
        stim_t it;
        if (run_started) begin
            nxt_s_valid = s_tvalid && !elem_taken_q;
            nxt_c_valid = cfg_valid && !size_taken_q;
            if (!nxt_s_valid && !nxt_c_valid && stim_q.size() > 0
                && $urandom_range(99) >= send_idle_pct) begin
                it = stim_q.pop_front();
                if (it.is_size) begin
                    nxt_c_valid = 1'b1;
                    cfg_data   <= it.data[CFG_W-1:0];
                end else begin
                    nxt_s_valid = 1'b1;
                    s_tdata    <= it.data;
                end
            end
            s_tvalid  <= nxt_s_valid;
            cfg_valid <= nxt_c_valid;
            m_tready  <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples on the rising edge, predicts and checks
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        inv_elem_t want;
        logic      any_fire;
        elem_taken_q <= s_tvalid && s_tready;
        size_taken_q <= cfg_valid && cfg_ready;
        any_fire = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                // size write also discards any partial load
                size_reg = cfg_data;
                load_pos = 0;
                any_fire = 1'b1;
            end
            if (s_tvalid && s_tready) begin
                load_element(s_tdata);
                any_fire = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                any_fire = 1'b1;
                results_seen++;
                if (inverse_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result data=%h last=%b user=%b",
                                 m_tdata, m_tlast, m_tuser);
                end else begin
                    want = inverse_q.pop_front();
                    if (m_tdata !== want.inv_val || m_tlast !== want.last
                        || m_tuser[0] !== want.singular || m_tuser[1] !== want.saturated) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: result %0d exp data=%h last=%b sing=%b sat=%b,",
                                      " got data=%h last=%b user=%b"},
                                     results_seen, want.inv_val, want.last, want.singular,
                                     want.saturated, m_tdata, m_tlast, m_tuser);
                    end
                    if (want.last) begin
                        matrices_done++;
                        if (want.singular) singular_seen_cnt++;
                        if (want.saturated) saturated_seen_cnt++;
                    end
                end
            end
            // watchdog on transaction activity
            if (any_fire) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("ERROR: no transaction for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, inverse_q.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_elem(logic [DATA_W-1:0] v);
        stim_t it;
        it.is_size = 1'b0;
        it.data    = v;
        stim_q.push_back(it);
        elems_sent++;
    endtask

    // wait until every transaction is out and every inverse element is back
    task automatic wait_quiet();
        while (stim_q.size() > 0 || s_tvalid || cfg_valid || inverse_q.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_size(logic [CFG_W-1:0] d);
        stim_t it;
        wait_quiet();
        it.is_size = 1'b1;
        it.data    = d;
        stim_q.push_back(it);
        wait_quiet();
    endtask

    // random element: mostly modest values, some zeros, some full-range words
    function automatic logic [DATA_W-1:0] rand_elem();
        int sel;
        sel = $urandom_range(99);
        if (sel < 12) return '0;
        if (sel < 22) return $urandom();
        if (sel < 30) return ($urandom_range(1)) ? FX_ONE : FX_NEG_ONE;
        return {{13{1'b0}}, 19'($urandom())} - 32'h0004_0000;  // about -4.0 .. +4.0
    endfunction

    task automatic push_matrix(int n);
        for (int c = 0; c < n * n; c++) push_elem(rand_elem());
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int size_pick;
        int n;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        elem_taken_q = 1'b0;
        size_taken_q = 1'b0;
        size_reg     = 4'(DIM_RESET);
        load_pos     = 0;
        for (int c = 0; c < CELLS; c++) lhs_mat[c] = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);
        run_started = 1'b1;

        // directed: 1x1 extremes
        write_size(4'd1);
        push_elem(32'h0000_0000);   // singular
        push_elem(32'h7FFF_FFFF);
        push_elem(32'h8000_0000);
        push_elem(FX_ONE);
        push_elem(FX_NEG_ONE);
        push_elem(32'h0000_0001);   // reciprocal clamps
        push_elem(32'hFFFF_FFFF);
        // size 0 behaves as 1
        write_size(4'd0);
        push_elem(32'h0002_0000);
        // 2x2: zero pivot needing a row swap, then a singular one
        write_size(4'd2);
        push_elem('0); push_elem(FX_ONE); push_elem(FX_ONE); push_elem('0);
        push_elem(FX_ONE); push_elem(FX_ONE); push_elem(FX_ONE); push_elem(FX_ONE);
        // partial 3x3 load abandoned by a size write
        write_size(4'd3);
        push_elem(32'h0003_0000); push_elem(FX_NEG_ONE); push_elem(32'h7FFF_FFFF);
        write_size(4'd2);
        push_elem(32'h7FFF_FFFF); push_elem(32'h8000_0000);
        push_elem(32'h8000_0000); push_elem(32'h0000_0001);

        // random part in three pressure phases
        for (int ph = 0; ph < 3; ph++) begin
            wait_quiet();
            send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 83 : 0;
            recv_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 37 : 0;
            while (elems_sent < 20 + 62 * (ph + 1)) begin
                size_pick = $urandom_range(99);
                if (ph == 2 && elems_sent > 150 && elems_sent < 170)
                    size_pick = 100;                   // one full-size matrix
                if (size_pick < 25) begin
                    n = $urandom_range(1, 4);
                    write_size(4'(n));
                end else if (size_pick == 100) begin
                    write_size(4'd15);                 // above the maximum: acts as 8
                end
                push_matrix(size_in_use());
                if ($urandom_range(9) == 0) wait_quiet();  // sender holds back
            end
        end

        wait_quiet();
        $display("Run covered %0d elements, %0d inverses (%0d singular, %0d saturated).",
                 elems_sent, matrices_done, singular_seen_cnt, saturated_seen_cnt);
        $display("Sizes 0..4 and 15 written, three handshake pressure phases, %0d results.",
                 results_seen);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
